// ----- hw/rtl/rpn_pkg.sv -----
//------------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants for the RPN stack calculator.
//------------------------------------------------------------------------------
package rpn_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_W          = 32;
    localparam int CMD_W           = 4;

    // token codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ADD  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_MUL  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_DIV  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_POW  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_LOG  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_SQRT = 4'd7;
    localparam logic [CMD_W-1:0] CMD_SEL  = 4'd8;
    localparam logic [CMD_W-1:0] CMD_EOL  = 4'd9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_LAT,
        ST_CALC,
        ST_WAIT,
        ST_WB,
        ST_EOL_RD,
        ST_EOL_LAT,
        ST_OUT
    } state_t;

    // arithmetic unit sequencer states
    typedef enum logic [2:0] {
        A_IDLE, A_DIV, A_POW_M1, A_POW_M2, A_LOG, A_SQRT, A_DONE
    } astate_t;

    // handshake between the sequencer and the arithmetic unit
    typedef struct packed {
        logic             start;
        logic [CMD_W-1:0] op;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic              ok;
        logic [DATA_W-1:0] res;
    } alu_rsp_t;

endpackage

// ----- hw/rtl/rpn_ram.sv -----
//------------------------------------------------------------------------------
// rpn_ram
// Generic single-port-write, single-port-read RAM with registered read.
//------------------------------------------------------------------------------
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/rpn_alu.sv -----
//------------------------------------------------------------------------------
// rpn_alu
// Multi-cycle arithmetic unit: one 32x32 multiplier and the div and sqrt step
// subtractors, stepped by a small counter for div, pow, log and sqrt.
//------------------------------------------------------------------------------
module rpn_alu
    import rpn_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  alu_req_t          req,
    input  logic [DATA_W-1:0] n1,
    input  logic [DATA_W-1:0] n2,
    input  logic [DATA_W-1:0] n3,
    output alu_rsp_t          rsp
);

    astate_t           st_reg, st_next;
    logic [DATA_W-1:0] a_reg, b_reg, acc_reg, q_reg, rem_reg;
    logic [5:0]        cnt_reg;
    logic              neg_reg, ok_reg;
    logic [DATA_W-1:0] res_reg;

    // shared multiplier; low half for mul/pow, full product for the log compare
    logic [DATA_W-1:0]   mul_a, mul_b, mul_p;
    logic [2*DATA_W-1:0] mul_full;
    assign mul_full = 64'(mul_a) * 64'(mul_b);
    assign mul_p    = mul_full[DATA_W-1:0];

    // div step
    logic [DATA_W:0]   rem_sh, rem_sub;
    assign rem_sh  = {rem_reg, q_reg[DATA_W-1]};
    assign rem_sub = rem_sh - {1'b0, b_reg};

    // sqrt step (restoring digit method, two bits per step)
    logic [DATA_W+1:0] sq_rem, sq_trial;
    assign sq_rem   = {rem_reg, q_reg[DATA_W-1 -: 2]};
    assign sq_trial = sq_rem - {acc_reg, 2'b01};

    logic [DATA_W-1:0] abs1, abs2;
    assign abs1 = n1[DATA_W-1] ? -n1 : n1;
    assign abs2 = n2[DATA_W-1] ? -n2 : n2;

    always_comb begin
        mul_a = a_reg;
        mul_b = b_reg;
        if (req.start) begin
            mul_a = n1;
            mul_b = n2;
        end else if (st_reg == A_POW_M1) begin
            mul_a = acc_reg;
            mul_b = a_reg;
        end else if (st_reg == A_POW_M2) begin
            mul_a = a_reg;
            mul_b = a_reg;
        end else if (st_reg == A_LOG) begin
            mul_a = acc_reg;
            mul_b = b_reg;
        end
    end

    // next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            A_IDLE: begin
                if (req.start) begin
                    case (req.op)
                        CMD_DIV:  st_next = (n2 == '0) ? A_DONE : A_DIV;
                        CMD_POW:  st_next = n2[DATA_W-1] ? A_DONE : A_POW_M1;
                        CMD_LOG:  st_next = ($signed(n2) <= 1 || $signed(n1) < 0 ||
                                             n1 < n2) ? A_DONE : A_LOG;
                        CMD_SQRT: st_next = n1[DATA_W-1] ? A_DONE : A_SQRT;
                        default:  st_next = A_DONE;
                    endcase
                end
            end
            A_DIV:    st_next = (cnt_reg == 6'd31) ? A_DONE : A_DIV;
            A_POW_M1: st_next = A_POW_M2;
            A_POW_M2: st_next = (cnt_reg == 6'd31) ? A_DONE : A_POW_M1;
            A_LOG:    st_next = (mul_full > {32'd0, a_reg} || cnt_reg == 6'd31)
                                ? A_DONE : A_LOG;
            A_SQRT:   st_next = (cnt_reg == 6'd15) ? A_DONE : A_SQRT;
            A_DONE:   st_next = A_IDLE;
            default:  st_next = A_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= A_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (st_reg)
            A_IDLE: begin
                if (req.start) begin
                    cnt_reg <= '0;
                    case (req.op)
                        CMD_ADD: begin
                            ok_reg  <= 1'b1;
                            res_reg <= n1 + n2;
                        end
                        CMD_SUB: begin
                            ok_reg  <= 1'b1;
                            res_reg <= n1 - n2;
                        end
                        CMD_MUL: begin
                            ok_reg  <= 1'b1;
                            res_reg <= mul_p;
                        end
                        CMD_SEL: begin
                            ok_reg  <= 1'b1;
                            res_reg <= (n1 == '0) ? n3 : n2;
                        end
                        CMD_DIV: begin
                            ok_reg  <= (n2 != '0);
                            res_reg <= '0;
                            q_reg   <= abs1;
                            b_reg   <= abs2;
                            rem_reg <= '0;
                            neg_reg <= n1[DATA_W-1] ^ n2[DATA_W-1];
                        end
                        CMD_POW: begin
                            ok_reg  <= ~n2[DATA_W-1];
                            res_reg <= '0;
                            acc_reg <= 32'd1;
                            a_reg   <= n1;
                            b_reg   <= n2;
                        end
                        CMD_LOG: begin
                            ok_reg  <= ($signed(n2) > 1);
                            res_reg <= ($signed(n1) < 0) ? '1 : '0;
                            a_reg   <= n1;
                            b_reg   <= n2;
                            acc_reg <= n2;
                        end
                        CMD_SQRT: begin
                            ok_reg  <= ~n1[DATA_W-1];
                            res_reg <= '0;
                            q_reg   <= n1;
                            rem_reg <= '0;
                            acc_reg <= '0;
                        end
                        default: begin
                            ok_reg  <= 1'b1;
                            res_reg <= '0;
                        end
                    endcase
                end
            end
            A_DIV: begin
                cnt_reg <= cnt_reg + 6'd1;
                if (!rem_sub[DATA_W]) begin
                    rem_reg <= rem_sub[DATA_W-1:0];
                    q_reg   <= {q_reg[DATA_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh[DATA_W-1:0];
                    q_reg   <= {q_reg[DATA_W-2:0], 1'b0};
                end
                if (cnt_reg == 6'd31) begin
                    res_reg <= neg_reg
                        ? -(rem_sub[DATA_W] ? {q_reg[DATA_W-2:0], 1'b0}
                                            : {q_reg[DATA_W-2:0], 1'b1})
                        :  (rem_sub[DATA_W] ? {q_reg[DATA_W-2:0], 1'b0}
                                            : {q_reg[DATA_W-2:0], 1'b1});
                end
            end
            A_POW_M1: begin
                if (b_reg[0]) begin
                    acc_reg <= mul_p;
                end
            end
            A_POW_M2: begin
                a_reg   <= mul_p;
                b_reg   <= {1'b0, b_reg[DATA_W-1:1]};
                cnt_reg <= cnt_reg + 6'd1;
                res_reg <= acc_reg;
            end
            A_LOG: begin
                // acc = b^(k+1) <= a here
                cnt_reg <= cnt_reg + 6'd1;
                res_reg <= {26'd0, cnt_reg} + 32'd1;
                acc_reg <= mul_p;
            end
            A_SQRT: begin
                cnt_reg <= cnt_reg + 6'd1;
                q_reg   <= {q_reg[DATA_W-3:0], 2'b00};
                if (!sq_trial[DATA_W+1]) begin
                    rem_reg <= sq_trial[DATA_W-1:0];
                    acc_reg <= {acc_reg[DATA_W-2:0], 1'b1};
                end else begin
                    rem_reg <= sq_rem[DATA_W-1:0];
                    acc_reg <= {acc_reg[DATA_W-2:0], 1'b0};
                end
                if (cnt_reg == 6'd15) begin
                    res_reg <= {acc_reg[DATA_W-2:0], ~sq_trial[DATA_W+1]};
                end
            end
            default: ;
        endcase
    end

    assign rsp.done = (st_reg == A_DONE);
    assign rsp.ok   = ok_reg;
    assign rsp.res  = res_reg;

endmodule

// ----- hw/rtl/rpn_stack_calculator.sv -----
//------------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse-Polish integer calculator over pre-parsed tokens.
//------------------------------------------------------------------------------
// Pow makes two multiplier passes per exponent bit.
// End of line: after accept the sequencer passes ST_EOL_RD and ST_EOL_LAT, then
// offers the result beat in ST_OUT until m_ready; next token taken the cycle
// after the result beat. One token in flight at a time.
// Reset (aresetn, sync, active low) clears depth and error; stack RAM is not
// cleared and its contents are only used below the current depth.
module rpn_stack_calculator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CMD_W-1:0]         s_cmd,
    input  logic signed [DATA_W-1:0] s_operand_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_line_result,
    output logic                     m_line_error
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg;
    logic              err_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [DATA_W-1:0] n1_reg, n2_reg, n3_reg;
    logic [DATA_W-1:0] out_res_reg;
    logic              out_err_reg;

    // RAM ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic [CW-1:0] need;
    always_comb begin
        case (s_cmd)
            CMD_SQRT: need = CW'(1);
            CMD_SEL:  need = CW'(3);
            default:  need = CW'(2);
        endcase
    end

    logic [CW-1:0] need_reg;
    always_comb begin
        case (cmd_reg)
            CMD_SQRT: need_reg = CW'(1);
            CMD_SEL:  need_reg = CW'(3);
            default:  need_reg = CW'(2);
        endcase
    end

    logic is_op;
    assign is_op = (s_cmd >= CMD_ADD) && (s_cmd <= CMD_SEL);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == CMD_EOL) begin
                        state_next = ST_EOL_RD;
                    end else if (is_op && count_reg >= need) begin
                        state_next = ST_RD1;
                    end
                end
            end
            ST_RD1:     state_next = ST_RD2;
            ST_RD2:     state_next = (need_reg == CW'(1)) ? ST_LAT : ST_RD3;
            ST_RD3:     state_next = ST_LAT;
            ST_LAT:     state_next = ST_CALC;
            ST_CALC:    state_next = ST_WAIT;
            ST_WAIT:    state_next = alu_rsp.done ? ST_WB : ST_WAIT;
            ST_WB:      state_next = ST_IDLE;
            ST_EOL_RD:  state_next = ST_EOL_LAT;
            ST_EOL_LAT: state_next = ST_OUT;
            ST_OUT:     state_next = m_ready ? ST_IDLE : ST_OUT;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // read address follows the operand being fetched; rdata is registered and lands in the next cycle
    always_comb begin
        ram_raddr = '0;
        case (state_reg)
            ST_RD1:  ram_raddr = AW'(count_reg - CW'(1));
            ST_RD2:  ram_raddr = AW'(count_reg - CW'(2));
            ST_RD3:  ram_raddr = AW'(count_reg - CW'(3));
            default: ram_raddr = '0;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        alu_req.start = (state_reg == ST_CALC);
        alu_req.op    = cmd_reg;
        ram_we        = 1'b0;
        ram_waddr     = AW'(count_reg);
        ram_wdata     = alu_rsp.res;
        if (state_reg == ST_IDLE && s_valid && s_cmd == CMD_PUSH && count_reg < DEPTH_C) begin
            ram_we    = 1'b1;
            ram_wdata = s_operand_value;
        end else if (state_reg == ST_WB && alu_rsp.ok) begin
            ram_we = 1'b1;
        end
        m_valid       = (state_reg == ST_OUT);
        m_line_result = out_res_reg;
        m_line_error  = out_err_reg;
    end

    // control and operand registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            err_reg   <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg <= s_cmd;
                        if (s_cmd == CMD_PUSH) begin
                            if (count_reg < DEPTH_C) begin
                                count_reg <= count_reg + CW'(1);
                            end else begin
                                err_reg <= 1'b1;
                            end
                        end else if (s_cmd == CMD_EOL) begin
                            out_err_reg <= err_reg || (count_reg != CW'(1));
                        end else if (!is_op || count_reg < need) begin
                            err_reg <= 1'b1;
                        end
                    end
                end
                ST_RD2: n1_reg <= ram_rdata;
                ST_RD3: n2_reg <= ram_rdata;
                ST_LAT: begin
                    // third operand of select lands here
                    if (need_reg == CW'(3)) begin
                        n3_reg <= ram_rdata;
                    end
                    count_reg <= count_reg - need_reg;
                end
                ST_WB: begin
                    if (alu_rsp.ok) begin
                        count_reg <= count_reg + CW'(1);
                    end else begin
                        err_reg <= 1'b1;
                    end
                end
                ST_EOL_LAT: begin
                    out_res_reg <= out_err_reg ? '0 : ram_rdata;
                    count_reg   <= '0;
                    err_reg     <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    rpn_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rpn_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .n1      (n1_reg),
        .n2      (n2_reg),
        .n3      (n3_reg),
        .rsp     (alu_rsp)
    );

    // stack depth never exceeds the configured size
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= DEPTH_C)
        else $error("stack depth out of range");

    // a result beat is only offered after an end-of-line token
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_EOL_LAT)
        else $error("unexpected result beat");

    // an error result always carries zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_error |-> m_line_result == '0)
        else $error("error beat with nonzero value");

    // arithmetic unit is only started while no token is accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        alu_req.start |-> !s_ready)
        else $error("alu started while idle");

endmodule

// ----- tb/tb_top.sv -----
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RPN stack calculator: directed token lines,
// then random well-formed and broken lines, checked against an internal model.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
    import rpn_pkg::*;
;

    localparam int DEPTH     = STACK_DEPTH_DEF;
    localparam int WD_LIMIT  = 20000;
    localparam int TAIL_CYC  = 200;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     err;
    } line_out_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_cmd = '0;
    logic signed [DATA_W-1:0] s_operand_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_line_result;
    logic                     m_line_error;

    // model state
    logic [DATA_W-1:0] calc_stack [DEPTH];
    int                calc_depth = 0;
    bit                calc_err = 1'b0;
    line_out_t         line_q[$];

    int  fail_count = 0;
    int  src_idle_pct = 0;
    int  dst_idle_pct = 0;
    int  quiet_cycles = 0;

    rpn_stack_calculator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_cmd(s_cmd), .s_operand_value(s_operand_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_line_result(m_line_result), .m_line_error(m_line_error)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // floor sqrt by binary search
    function automatic logic [31:0] isqrt(logic [31:0] n);
        logic [31:0] lo, hi, mid;
        lo = 0;
        hi = 46341;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (64'(mid) * 64'(mid) <= 64'(n)) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    // apply one token to the model, queue the line result on end of line
    task automatic calc_token(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val);
        int                need;
        logic [31:0]       u1, u2, u3, r, b, e;
        longint            s1, s2, n;
        bit                ok;
        line_out_t         lo;
        u2 = 0;
        u3 = 0;
        r = 0;
        ok = 1'b1;
        if (cmd == CMD_EOL) begin
            if (calc_depth == 1 && !calc_err) begin
                lo.value = calc_stack[0];
                lo.err = 1'b0;
            end else begin
                lo.value = '0;
                lo.err = 1'b1;
            end
            line_q.push_back(lo);
            calc_depth = 0;
            calc_err = 1'b0;
            return;
        end
        if (cmd == CMD_PUSH) begin
            if (calc_depth >= DEPTH) calc_err = 1'b1;
            else calc_stack[calc_depth++] = val;
            return;
        end
        if (cmd > CMD_EOL) begin
            calc_err = 1'b1;
            return;
        end
        need = (cmd == CMD_SQRT) ? 1 : (cmd == CMD_SEL) ? 3 : 2;
        if (calc_depth < need) begin
            calc_err = 1'b1;
            return;
        end
        u1 = calc_stack[calc_depth-1];
        if (need >= 2) u2 = calc_stack[calc_depth-2];
        if (need >= 3) u3 = calc_stack[calc_depth-3];
        calc_depth -= need;
        s1 = longint'(signed'(u1));
        s2 = longint'(signed'(u2));
        case (cmd)
            CMD_ADD: r = u1 + u2;
            CMD_SUB: r = u1 - u2;
            CMD_MUL: r = u1 * u2;
            CMD_DIV: begin
                if (s2 == 0) ok = 1'b0;
                else r = 32'(s1 / s2);
            end
            CMD_POW: begin
                if (s2 < 0) ok = 1'b0;
                else begin
                    r = 1;
                    b = u1;
                    e = u2;
                    while (e != 0) begin
                        if (e[0]) r = r * b;
                        b = b * b;
                        e = e >> 1;
                    end
                end
            end
            CMD_LOG: begin
                if (s2 <= 1) ok = 1'b0;
                else if (s1 < 0) r = '1;
                else begin
                    n = s1;
                    while (n >= s2) begin
                        n = n / s2;
                        r++;
                    end
                end
            end
            CMD_SQRT: begin
                if (s1 < 0) ok = 1'b0;
                else r = isqrt(u1);
            end
            default: r = (u1 == 0) ? u3 : u2;
        endcase
        if (ok) calc_stack[calc_depth++] = r;
        else calc_err = 1'b1;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    // send one token beat; model updated at acceptance
    task automatic send_token(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_operand_value <= val;
        do @(posedge aclk); while (!s_ready);
        calc_token(cmd, val);
        @(negedge aclk);
    endtask

    task automatic push(int v);
        send_token(CMD_PUSH, 32'(v));
    endtask

    task automatic eol();
        send_token(CMD_EOL, 32'($urandom));
    endtask

    // receiver stalls
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // result checker and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WD_LIMIT) begin
                $display("[rpn_stack_calculator] ERROR");
                $finish;
            end
            if (m_valid && m_ready) begin
                if (line_q.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    if (m_line_result !== line_q[0].value)
                        report_mismatch("line_result", m_line_result, line_q[0].value);
                    if (m_line_error !== line_q[0].err)
                        report_mismatch("line_error", m_line_error, line_q[0].err);
                    void'(line_q.pop_front());
                end
            end
        end
    end

    task automatic test_arith();
        logic [CMD_W-1:0] op;
        for (int c = 1; c <= 7; c++) begin
            op = CMD_W'(c);
            push(7); push(100); send_token(op, 0); eol();
        end
        push(-5); push(3); push(0); send_token(CMD_SEL, 0); eol();
        push(-5); push(3); push(1); send_token(CMD_SEL, 0); eol();
    endtask

    task automatic test_special();
        push(0); push(5); send_token(CMD_DIV, 0); eol();
        push(-1); push(32'h8000_0000); send_token(CMD_DIV, 0); eol();
        push(-1); push(2); send_token(CMD_POW, 0); eol();
        push(1); push(9); send_token(CMD_LOG, 0); eol();
        push(3); push(-9); send_token(CMD_LOG, 0); eol();
        push(1); send_token(CMD_SQRT, 0); eol();
        push(32'h7fff_ffff); send_token(CMD_SQRT, 0); eol();
        push(-4); send_token(CMD_SQRT, 0); eol();
        send_token(CMD_ADD, 0); eol();
        send_token(4'd12, 0); push(1); eol();
        push(1); push(2); eol();
        eol();
        for (int i = 0; i <= DEPTH; i++) push(i);
        eol();
        for (int i = 0; i < DEPTH; i++) push(32'hffff_ffff);
        for (int i = 1; i < DEPTH; i++) send_token(CMD_ADD, 0);
        eol();
    endtask

    function automatic logic [DATA_W-1:0] rand_val();
        case ($urandom_range(5))
            0: return 32'($urandom_range(3)) - 1;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'($urandom_range(40));
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random(int n_items);
        int sent, want;
        logic [CMD_W-1:0] op;
        sent = 0;
        while (sent < n_items) begin
            want = 0;
            for (int k = $urandom_range(8); k >= 0 || want > 0 || k > -1; ) begin
                if (want < 3 || ($urandom_range(2) == 0 && want < DEPTH - 1 && k > 0)) begin
                    push(int'(rand_val()));
                    want++;
                end else begin
                    op = CMD_W'($urandom_range(8, 1));
                    if ($urandom_range(30) == 0) op = CMD_W'($urandom_range(15, 10));
                    send_token(op, rand_val());
                    want -= (op == CMD_SQRT) ? 0 : (op == CMD_SEL) ? 2 : 1;
                    if (want < 1) want = 1;
                end
                sent++;
                k--;
                if (k < 0 && ($urandom_range(5) == 0 || want <= 1)) break;
            end
            eol();
            sent++;
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (line_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYC) @(posedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        src_idle_pct = 31;
        dst_idle_pct = 48;
        test_arith();
        test_special();
        test_random(460);
        src_idle_pct = 48;
        dst_idle_pct = 31;
        test_random(460);
        src_idle_pct = 0;
        dst_idle_pct = 0;
        test_random(410);
        drain();
        if (fail_count == 0) $display("[rpn_stack_calculator] OK");
        else $display("[rpn_stack_calculator] ERROR");
        $finish;
    end
endmodule
